// File: hdl/ggx_pkg.sv
package ggx_pkg;

    // fixed point: unsigned q2.30, one = 2^30
    localparam int          Q_BITS  = 30;
    localparam logic [31:0] Q_ONE   = 32'h4000_0000;
    localparam logic [29:0] PI8_Q28 = 30'd843314857;
    localparam logic [15:0] Q15_ONE = 16'h8000;

    // stages from the accepting edge to the result register
    localparam int LATENCY = 88;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] view_x;
        logic signed [15:0] view_y;
        logic signed [15:0] view_z;
        logic signed [15:0] light_x;
        logic signed [15:0] light_y;
        logic signed [15:0] light_z;
        logic [15:0]        rough;
        logic [15:0]        f0_red;
    } sample_t;

    typedef struct packed {
        logic [15:0] specular;
        logic        degenerate;
    } result_t;

    // q30 product, truncated
    function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return p[61:30];
    endfunction

    // q1.15 scalar saturated to one, then to q30
    function automatic logic [31:0] sat_q15(input logic [15:0] v);
        logic [15:0] x;
        x = (v > Q15_ONE) ? Q15_ONE : v;
        return {1'b0, x, 15'd0};
    endfunction

endpackage

// File: hdl/ggx_specular_brdf.sv
// GGX specular term, one item per clock with no back-pressure: busy is always
// low, so an item can be started in every cycle, and its result comes out on
// result with done high, in the order of the items. The latency is set by the
// chain of pipelined units: the half-vector length root (31 stages), the two
// half-vector dot divisions (30 stages) and the final quotient (15 stages),
// with register stages for the products between them. The receiver must take
// every result in the cycle that done is high.
module ggx_specular_brdf
    import ggx_pkg::*;
#(
    parameter int VEC_FRAC_BITS = 14
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  sample_t sample,
    output logic    done,
    output result_t result
);

    localparam int P   = VEC_FRAC_BITS;
    localparam int SHR = (2 * P >= Q_BITS) ? 2 * P - Q_BITS : 0;
    localparam int SHL = (2 * P <  Q_BITS) ? Q_BITS - 2 * P : 0;
    localparam int NSH = 44 - P;

    // clamped dot to q30
    function automatic logic [31:0] dot_q(input logic signed [33:0] d);
        logic [63:0] u;
        u = 64'(unsigned'(d));
        if (d <= 0)
            return '0;
        else if (u >= (64'd1 << (2 * P)))
            return Q_ONE;
        else
            return 32'((u >> SHR) << SHL);
    endfunction

    logic [LATENCY-1:0] vld_reg;

    // valid bits travel with the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LATENCY-2:0], start};
    end

    assign busy = 1'b0;
    assign done = vld_reg[LATENCY-1];

    // stage 1: component products
    logic signed [15:0] n_c [3];
    logic signed [15:0] v_c [3];
    logic signed [15:0] l_c [3];
    logic signed [16:0] s_c [3];

    always_comb
    begin
        n_c[0] = sample.normal_x;
        n_c[1] = sample.normal_y;
        n_c[2] = sample.normal_z;
        v_c[0] = sample.view_x;
        v_c[1] = sample.view_y;
        v_c[2] = sample.view_z;
        l_c[0] = sample.light_x;
        l_c[1] = sample.light_y;
        l_c[2] = sample.light_z;
        for (int i = 0; i < 3; i++)
        begin
            s_c[i] = 17'(v_c[i]) + 17'(l_c[i]);
        end
    end

    logic signed [31:0] pnl_reg [3];
    logic signed [31:0] pnv_reg [3];
    logic signed [32:0] pns_reg [3];
    logic signed [32:0] pls_reg [3];
    logic signed [33:0] pss_reg [3];
    logic [31:0]        r_s1_reg;
    logic [31:0]        f0_s1_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pnl_reg[i] <= n_c[i] * l_c[i];
            pnv_reg[i] <= n_c[i] * v_c[i];
            pns_reg[i] <= 33'(n_c[i]) * 33'(s_c[i]);
            pls_reg[i] <= 33'(l_c[i]) * 33'(s_c[i]);
            pss_reg[i] <= 34'(s_c[i]) * 34'(s_c[i]);
        end
        r_s1_reg  <= sat_q15(sample.rough);
        f0_s1_reg <= sat_q15(sample.f0_red);
    end

    // stage 2: dot sums
    logic signed [33:0] nl_reg;
    logic signed [33:0] nv_reg;
    logic signed [34:0] ns_reg;
    logic signed [34:0] ls_reg;
    logic [33:0]        ss_reg;
    logic [31:0]        r_s2_reg;
    logic [31:0]        f0_s2_reg;

    always_ff @(posedge clk)
    begin
        nl_reg    <= 34'(pnl_reg[0]) + 34'(pnl_reg[1]) + 34'(pnl_reg[2]);
        nv_reg    <= 34'(pnv_reg[0]) + 34'(pnv_reg[1]) + 34'(pnv_reg[2]);
        ns_reg    <= 35'(pns_reg[0]) + 35'(pns_reg[1]) + 35'(pns_reg[2]);
        ls_reg    <= 35'(pls_reg[0]) + 35'(pls_reg[1]) + 35'(pls_reg[2]);
        ss_reg    <= 34'(35'(pss_reg[0]) + 35'(pss_reg[1]) + 35'(pss_reg[2]));
        r_s2_reg  <= r_s1_reg;
        f0_s2_reg <= f0_s1_reg;
    end

    // half vector length, stage 2 to 33
    logic [30:0] q_s33;

    ggx_sqrt_pipe #(.W(62)) u_len_sqrt (
        .clk  (clk),
        .x    ({ss_reg, 28'd0}),
        .root (q_s33)
    );

    // stage 3: light and view cosines, r squared
    logic [31:0] ndl_s3_reg;
    logic [31:0] ndv_s3_reg;
    logic [31:0] a2_s3_reg;
    logic        ss0_s3_reg;

    always_ff @(posedge clk)
    begin
        ndl_s3_reg <= dot_q(nl_reg);
        ndv_s3_reg <= dot_q(nv_reg);
        a2_s3_reg  <= qmul(r_s2_reg, r_s2_reg);
        ss0_s3_reg <= (ss_reg == '0);
    end

    // stage 4: squares for the visibility roots
    logic [31:0] ndl2_s4_reg;
    logic [31:0] ndv2_s4_reg;
    logic [31:0] oma2_s4_reg;
    logic [31:0] a2_s4_reg;
    logic [1:0]  flg_s4_reg;

    always_ff @(posedge clk)
    begin
        ndl2_s4_reg <= qmul(ndl_s3_reg, ndl_s3_reg);
        ndv2_s4_reg <= qmul(ndv_s3_reg, ndv_s3_reg);
        oma2_s4_reg <= Q_ONE - a2_s3_reg;
        a2_s4_reg   <= a2_s3_reg;
        flg_s4_reg  <= {ss0_s3_reg, (ndl_s3_reg == '0) || (ndv_s3_reg == '0)};
    end

    // stage 5: radicands
    logic [31:0] argv_s5_reg;
    logic [31:0] argl_s5_reg;

    always_ff @(posedge clk)
    begin
        argv_s5_reg <= qmul(ndv2_s4_reg, oma2_s4_reg) + a2_s4_reg;
        argl_s5_reg <= qmul(ndl2_s4_reg, oma2_s4_reg) + a2_s4_reg;
    end

    logic [30:0] sqv_s36;
    logic [30:0] sql_s36;

    // q30 root: radicand scaled by 2^30
    ggx_sqrt_pipe #(.W(62)) u_vis_sqrt_v (
        .clk  (clk),
        .x    ({1'b0, argv_s5_reg[30:0], 30'd0}),
        .root (sqv_s36)
    );

    ggx_sqrt_pipe #(.W(62)) u_vis_sqrt_l (
        .clk  (clk),
        .x    ({1'b0, argl_s5_reg[30:0], 30'd0}),
        .root (sql_s36)
    );

    logic [63:0] ndlv_s36;

    ggx_delay #(.W(64), .N(33)) u_d_ndlv (
        .clk (clk),
        .d   ({ndl_s3_reg, ndv_s3_reg}),
        .q   (ndlv_s36)
    );

    // stages 37 and 38: visibility sum
    logic [31:0] ggv_reg;
    logic [31:0] ggl_reg;
    logic [31:0] gs_reg;

    always_ff @(posedge clk)
    begin
        ggv_reg <= qmul(ndlv_s36[63:32], {1'b0, sqv_s36});
        ggl_reg <= qmul(ndlv_s36[31:0], {1'b0, sql_s36});
        gs_reg  <= ggv_reg + ggl_reg;
    end

    // stage 34: half vector dot setup
    logic [69:0] nsls_s33;

    ggx_delay #(.W(70), .N(31)) u_d_nsls (
        .clk (clk),
        .d   ({ns_reg, ls_reg}),
        .q   (nsls_s33)
    );

    logic signed [34:0] ns_s33;
    logic signed [34:0] ls_s33;
    logic [63:0]        qcmp;
    logic [99:0]        nwide;
    logic [99:0]        lwide;

    always_comb
    begin
        ns_s33 = nsls_s33[69:35];
        ls_s33 = nsls_s33[34:0];
        qcmp   = 64'(q_s33) << P;
        nwide  = {65'd0, ns_s33} << NSH;
        lwide  = {65'd0, ls_s33} << NSH;
    end

    logic [30:0] nhi_reg;
    logic [29:0] nlo_reg;
    logic [30:0] lhi_reg;
    logic [29:0] llo_reg;
    logic [30:0] q_s34_reg;
    logic [3:0]  hflg_s34_reg;

    always_ff @(posedge clk)
    begin
        nhi_reg      <= nwide[60:30];
        nlo_reg      <= nwide[29:0];
        lhi_reg      <= lwide[60:30];
        llo_reg      <= lwide[29:0];
        q_s34_reg    <= q_s33;
        hflg_s34_reg <= {(ns_s33 <= 0), ((64'(ns_s33) << 14) >= qcmp),
                         (ls_s33 <= 0), ((64'(ls_s33) << 14) >= qcmp)};
    end

    logic [29:0] ndh_q_s64;
    logic [29:0] ldh_q_s64;
    logic [3:0]  hflg_s64;

    ggx_div_pipe #(.DW(31), .QW(30)) u_div_ndh (
        .clk     (clk),
        .hi      (nhi_reg),
        .lo      (nlo_reg),
        .divisor (q_s34_reg),
        .quot    (ndh_q_s64)
    );

    ggx_div_pipe #(.DW(31), .QW(30)) u_div_ldh (
        .clk     (clk),
        .hi      (lhi_reg),
        .lo      (llo_reg),
        .divisor (q_s34_reg),
        .quot    (ldh_q_s64)
    );

    ggx_delay #(.W(4), .N(30)) u_d_hflg (
        .clk (clk),
        .d   (hflg_s34_reg),
        .q   (hflg_s64)
    );

    // stage 65: clamp half vector cosines
    logic [31:0] ndh_reg;
    logic [31:0] ldh_reg;

    always_ff @(posedge clk)
    begin
        if (hflg_s64[3])
            ndh_reg <= '0;
        else if (hflg_s64[2])
            ndh_reg <= Q_ONE;
        else
            ndh_reg <= {2'b00, ndh_q_s64};
        if (hflg_s64[1])
            ldh_reg <= '0;
        else if (hflg_s64[0])
            ldh_reg <= Q_ONE;
        else
            ldh_reg <= {2'b00, ldh_q_s64};
    end

    // delayed operands for the tail
    logic [31:0] r_s65;
    logic [31:0] f0_s68;
    logic [31:0] a2_s69;
    logic [31:0] ndv_s68;
    logic [31:0] gs_s69;
    logic [1:0]  flg_s69;

    ggx_delay #(.W(32), .N(63)) u_d_r (
        .clk (clk), .d (r_s2_reg), .q (r_s65)
    );

    ggx_delay #(.W(32), .N(66)) u_d_f0 (
        .clk (clk), .d (f0_s2_reg), .q (f0_s68)
    );

    ggx_delay #(.W(32), .N(66)) u_d_a2 (
        .clk (clk), .d (a2_s3_reg), .q (a2_s69)
    );

    ggx_delay #(.W(32), .N(32)) u_d_ndv (
        .clk (clk), .d (ndlv_s36[31:0]), .q (ndv_s68)
    );

    ggx_delay #(.W(32), .N(31)) u_d_gs (
        .clk (clk), .d (gs_reg), .q (gs_s69)
    );

    ggx_delay #(.W(2), .N(65)) u_d_flg (
        .clk (clk), .d (flg_s4_reg), .q (flg_s69)
    );

    // stages 66 to 70: distribution, fresnel power, numerator
    logic [31:0] a_s66_reg;
    logic [31:0] hh_s66_reg;
    logic [31:0] t_s66_reg;
    logic [31:0] t2_s66_reg;
    logic [31:0] dd_s67_reg;
    logic [31:0] t4_s67_reg;
    logic [31:0] t_s67_reg;
    logic [31:0] t5_s68_reg;
    logic [31:0] dd2_s68_reg;
    logic        dd0_s68_reg;
    logic [31:0] fr_s69_reg;
    logic [31:0] y_s69_reg;
    logic        dd0_s69_reg;
    logic [31:0] num_s70_reg;
    logic [31:0] x_s70_reg;
    logic        degp_s70_reg;

    always_ff @(posedge clk)
    begin
        a_s66_reg    <= qmul(ndh_reg, r_s65);
        hh_s66_reg   <= qmul(ndh_reg, ndh_reg);
        t_s66_reg    <= Q_ONE - ldh_reg;
        t2_s66_reg   <= qmul(Q_ONE - ldh_reg, Q_ONE - ldh_reg);

        dd_s67_reg   <= Q_ONE - hh_s66_reg + qmul(a_s66_reg, a_s66_reg);
        t4_s67_reg   <= qmul(t2_s66_reg, t2_s66_reg);
        t_s67_reg    <= t_s66_reg;

        t5_s68_reg   <= qmul(t4_s67_reg, t_s67_reg);
        dd2_s68_reg  <= qmul(dd_s67_reg, dd_s67_reg);
        dd0_s68_reg  <= (dd_s67_reg == '0);

        fr_s69_reg   <= f0_s68 + qmul(Q_ONE - f0_s68, t5_s68_reg);
        y_s69_reg    <= qmul(dd2_s68_reg, ndv_s68);
        dd0_s69_reg  <= dd0_s68_reg;

        num_s70_reg  <= qmul(a2_s69, fr_s69_reg);
        x_s70_reg    <= qmul(y_s69_reg, gs_s69);
        degp_s70_reg <= flg_s69[1] | flg_s69[0] | dd0_s69_reg | (gs_s69 == '0);
    end

    // stage 71: denominator carries 8 pi
    logic [61:0] den_prod;
    logic [36:0] den_s71_reg;
    logic [31:0] num_s71_reg;
    logic        degp_s71_reg;

    assign den_prod = 62'(x_s70_reg) * 62'(PI8_Q28);

    always_ff @(posedge clk)
    begin
        den_s71_reg  <= den_prod[61:25];
        num_s71_reg  <= num_s70_reg;
        degp_s71_reg <= degp_s70_reg;
    end

    // stage 72: final quotient setup
    logic [36:0] num_s72_reg;
    logic [36:0] den_s72_reg;
    logic [1:0]  fin_s72_reg;

    always_ff @(posedge clk)
    begin
        num_s72_reg <= 37'(num_s71_reg);
        den_s72_reg <= den_s71_reg;
        fin_s72_reg <= {degp_s71_reg | (den_s71_reg == '0),
                        37'(num_s71_reg) >= den_s71_reg};
    end

    logic [14:0] spec_q_s87;
    logic [1:0]  fin_s87;

    ggx_div_pipe #(.DW(37), .QW(15)) u_div_spec (
        .clk     (clk),
        .hi      (num_s72_reg),
        .lo      (15'd0),
        .divisor (den_s72_reg),
        .quot    (spec_q_s87)
    );

    ggx_delay #(.W(2), .N(15)) u_d_fin (
        .clk (clk), .d (fin_s72_reg), .q (fin_s87)
    );

    // stage 88: result register
    result_t result_reg;

    always_ff @(posedge clk)
    begin
        result_reg.degenerate <= fin_s87[1];
        if (fin_s87[1] || fin_s87[0])
            result_reg.specular <= Q15_ONE;
        else
            result_reg.specular <= {1'b0, spec_q_s87};
    end

    assign result = result_reg;

endmodule

// File: hdl/ggx_delay.sv
module ggx_delay #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] pipe_reg [N];

    // plain shift line, one stage per cycle
    always_ff @(posedge clk)
    begin
        pipe_reg[0] <= d;
        for (int i = 1; i < N; i++)
        begin
            pipe_reg[i] <= pipe_reg[i-1];
        end
    end

    assign q = pipe_reg[N-1];

endmodule

// File: hdl/ggx_sqrt_pipe.sv
module ggx_sqrt_pipe #(
    parameter int W = 62
) (
    input  logic             clk,
    input  logic [W-1:0]     x,
    output logic [W/2-1:0]   root
);

    localparam int RW = W / 2;

    logic [RW:0]   rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [W-1:0]  x_reg    [RW];

    // one result bit per stage, digit by digit
    for (genvar k = 0; k < RW; k++)
    begin : g_step
        logic [RW:0]   rem_in;
        logic [RW-1:0] root_in;
        logic [W-1:0]  x_in;
        logic [RW+2:0] acc;
        logic [RW+2:0] trial;
        logic          take;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = x;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign x_in    = x_reg[k-1];
        end

        always_comb
        begin
            acc   = {rem_in, x_in[W-1:W-2]};
            trial = {1'b0, root_in, 2'b01};
            take  = (acc >= trial);
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= take ? (RW+1)'(acc - trial) : acc[RW:0];
            root_reg[k] <= {root_in[RW-2:0], take};
            x_reg[k]    <= {x_in[W-3:0], 2'b00};
        end
    end

    assign root = root_reg[RW-1];

endmodule

// File: hdl/ggx_div_pipe.sv
module ggx_div_pipe #(
    parameter int DW = 31,
    parameter int QW = 30
) (
    input  logic          clk,
    input  logic [DW-1:0] hi,
    input  logic [QW-1:0] lo,
    input  logic [DW-1:0] divisor,
    output logic [QW-1:0] quot
);

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] lo_reg  [QW];
    logic [DW-1:0] dv_reg  [QW];
    logic [QW-1:0] q_reg   [QW];

    // restoring div, a quotient bit per stage; user keeps hi < divisor, unchecked
    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [DW-1:0] rem_in;
        logic [QW-1:0] lo_in;
        logic [DW-1:0] dv_in;
        logic [QW-1:0] q_in;
        logic [DW:0]   acc;
        logic          take;

        if (k == 0)
        begin : g_first
            assign rem_in = hi;
            assign lo_in  = lo;
            assign dv_in  = divisor;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign lo_in  = lo_reg[k-1];
            assign dv_in  = dv_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        always_comb
        begin
            acc  = {rem_in, lo_in[QW-1]};
            take = (acc >= {1'b0, dv_in});
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= take ? DW'(acc - {1'b0, dv_in}) : acc[DW-1:0];
            lo_reg[k]  <= lo_in << 1;
            dv_reg[k]  <= dv_in;
            q_reg[k]   <= {q_in[QW-2:0], take};
        end
    end

    assign quot = q_reg[QW-1];

endmodule

// File: hdl/ggx_chk.sv
module ggx_chk
    import ggx_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // no back-pressure towards the source
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // every result comes from an item accepted a fixed latency earlier
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without matching item");

    // result stays within one
    a_spec_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.specular <= Q15_ONE))
        else $error("specular above one");

    // a forced result is exactly one
    a_deg_one: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.degenerate) |-> (result.specular == Q15_ONE))
        else $error("degenerate result not one");

endmodule

bind ggx_specular_brdf ggx_chk u_ggx_chk (.*);
